// File: sv/kss_pkg.sv
// Package: shared types, sizes and codes of the k-th smallest select unit.
`default_nettype none

package kss_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int RANK_W    = 9;
    localparam int WORD_W    = 32;
    localparam int CMP_W     = (RANK_W > CNT_W) ? RANK_W : CNT_W;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CNT_W:0]           t_wide;
    typedef logic [CMP_W-1:0]         t_cmp;
    typedef logic [RANK_W-1:0]        t_rank;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANK     = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MRD,
        S_MWR,
        S_FRD,
        S_FCAP,
        S_RES
    } t_state;

endpackage

`default_nettype wire

// File: sv/kss_in_if.sv
// Interface: input item channel (value, last) with valid/ready handshake.
`default_nettype none

interface kss_in_if;
    logic          valid;
    logic          ready;
    kss_pkg::t_word value;
    logic          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// File: sv/kss_out_if.sv
// Interface: result channel (selected, status) with valid/ready handshake.
`default_nettype none

interface kss_out_if;
    logic             valid;
    logic             ready;
    kss_pkg::t_word   selected;
    kss_pkg::t_status status;

    modport source (output valid, output selected, output status, input ready);
    modport sink   (input valid, input selected, input status, output ready);
endinterface

`default_nettype wire

// File: sv/kth_smallest_select_unit.sv
// Top level: loads a data set, merge-sorts it between two memories, reports the rank-th value.
// Load: one input transfer per cycle in S_LOAD; the item flagged last starts the selection.
// Sort: ceil(log2 n) bottom-up merge passes; each element is read, then compared and written,
//   ping-ponging between the element store and the scratch memory.
// Loading pauses until the result is staged.
// Reset: control state clears, rank returns to 1; the memories are not cleared.
`default_nettype none

module kth_smallest_select_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [kss_pkg::RANK_W-1:0] i_cfg_wdata,
    kss_in_if.sink                i_data,
    kss_out_if.source             o_result
);

    // Memories: element store (A) and merge scratch (B).
    kss_pkg::t_word mem_a [kss_pkg::MAX_ITEMS];
    kss_pkg::t_word mem_b [kss_pkg::MAX_ITEMS];

    kss_pkg::t_state  r_state, n_state;
    kss_pkg::t_cnt    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    kss_pkg::t_rank   r_rank;
    kss_pkg::t_cnt    r_w, n_w;
    kss_pkg::t_cnt    r_i, n_i;
    kss_pkg::t_cnt    r_j, n_j;
    kss_pkg::t_cnt    r_k, n_k;
    kss_pkg::t_cnt    r_mid, n_mid;
    kss_pkg::t_cnt    r_hi, n_hi;
    logic             r_src, n_src;
    kss_pkg::t_word   r_res_sel, n_res_sel;
    kss_pkg::t_status r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    kss_pkg::t_word   r_out_sel, n_out_sel;
    kss_pkg::t_status r_out_status, n_out_status;

    kss_pkg::t_word   r_qa0, r_qa1, r_qb0, r_qb1;

    logic             a_we, b_we;
    kss_pkg::t_addr   a_waddr, b_waddr;
    kss_pkg::t_word   a_wdata, b_wdata;
    kss_pkg::t_addr   rd_addr0, rd_addr1;

    logic             load_fire;
    kss_pkg::t_cnt    cnt_after;
    logic             ovf_after;
    logic             rank_bad;
    kss_pkg::t_word   qi, qj;
    logic             take_i;
    kss_pkg::t_word   merge_data;
    logic             last_in_blk;
    logic             pass_end;
    logic             sort_end;
    kss_pkg::t_cnt    w2;
    logic             out_free;

    function automatic kss_pkg::t_cnt clamp_n(kss_pkg::t_wide sum, kss_pkg::t_cnt n);
        return (sum > kss_pkg::t_wide'(n)) ? n : kss_pkg::t_cnt'(sum);
    endfunction

    assign load_fire = i_data.valid && i_data.ready;
    assign cnt_after = (r_cnt < kss_pkg::t_cnt'(kss_pkg::MAX_ITEMS)) ?
                       r_cnt + kss_pkg::t_cnt'(1) : r_cnt;
    assign ovf_after = r_ovf || (r_cnt == kss_pkg::t_cnt'(kss_pkg::MAX_ITEMS));
    assign rank_bad  = (r_rank == '0) ||
                       (kss_pkg::t_cmp'(r_rank) > kss_pkg::t_cmp'(cnt_after));

    assign qi = r_src ? r_qb0 : r_qa0;
    assign qj = r_src ? r_qb1 : r_qa1;
    // Left run wins ties; an exhausted run never wins.
    assign take_i      = (r_i < r_mid) && ((r_j >= r_hi) || (qi <= qj));
    assign merge_data  = take_i ? qi : qj;
    assign last_in_blk = (r_k + kss_pkg::t_cnt'(1)) == r_hi;
    assign pass_end    = last_in_blk && (r_hi == r_cnt);
    assign w2          = kss_pkg::t_cnt'(r_w << 1);
    assign sort_end    = pass_end && (w2 >= r_cnt);
    assign out_free    = !r_out_valid || o_result.ready;

    assign i_data.ready      = (r_state == kss_pkg::S_LOAD);
    assign o_result.valid    = r_out_valid;
    assign o_result.selected = r_out_sel;
    assign o_result.status   = r_out_status;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kss_pkg::S_LOAD: begin
                if (load_fire && i_data.last) begin
                    if (ovf_after || rank_bad) begin
                        n_state = kss_pkg::S_RES;
                    end else if (cnt_after <= kss_pkg::t_cnt'(1)) begin
                        n_state = kss_pkg::S_FRD;
                    end else begin
                        n_state = kss_pkg::S_MRD;
                    end
                end
            end
            kss_pkg::S_MRD:  n_state = kss_pkg::S_MWR;
            kss_pkg::S_MWR:  n_state = sort_end ? kss_pkg::S_FRD : kss_pkg::S_MRD;
            kss_pkg::S_FRD:  n_state = kss_pkg::S_FCAP;
            kss_pkg::S_FCAP: n_state = kss_pkg::S_RES;
            kss_pkg::S_RES: begin
                if (out_free) begin
                    n_state = kss_pkg::S_LOAD;
                end
            end
            default: n_state = kss_pkg::S_LOAD;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        n_w          = r_w;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_mid        = r_mid;
        n_hi         = r_hi;
        n_src        = r_src;
        n_res_sel    = r_res_sel;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_sel    = r_out_sel;
        n_out_status = r_out_status;
        a_we         = 1'b0;
        b_we         = 1'b0;
        a_waddr      = kss_pkg::t_addr'(r_cnt);
        b_waddr      = kss_pkg::t_addr'(r_k);
        a_wdata      = i_data.value;
        b_wdata      = merge_data;
        rd_addr0     = kss_pkg::t_addr'(r_i);
        rd_addr1     = kss_pkg::t_addr'(r_j);

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            kss_pkg::S_LOAD: begin
                if (load_fire) begin
                    a_we  = (r_cnt < kss_pkg::t_cnt'(kss_pkg::MAX_ITEMS));
                    n_cnt = cnt_after;
                    n_ovf = ovf_after;
                    if (i_data.last) begin
                        n_res_sel = '0;
                        if (ovf_after) begin
                            n_res_status = kss_pkg::ST_TOO_MANY;
                        end else if (rank_bad) begin
                            n_res_status = kss_pkg::ST_RANK;
                        end else begin
                            n_res_status = kss_pkg::ST_OK;
                        end
                        n_w   = kss_pkg::t_cnt'(1);
                        n_src = 1'b0;
                        n_i   = '0;
                        n_k   = '0;
                        n_mid = clamp_n(kss_pkg::t_wide'(1), cnt_after);
                        n_hi  = clamp_n(kss_pkg::t_wide'(2), cnt_after);
                        n_j   = clamp_n(kss_pkg::t_wide'(1), cnt_after);
                    end
                end
            end
            kss_pkg::S_MWR: begin
                // Destination is always the memory opposite the source.
                a_we    = r_src;
                b_we    = !r_src;
                a_waddr = kss_pkg::t_addr'(r_k);
                a_wdata = merge_data;
                n_k     = r_k + kss_pkg::t_cnt'(1);
                if (take_i) begin
                    n_i = r_i + kss_pkg::t_cnt'(1);
                end else begin
                    n_j = r_j + kss_pkg::t_cnt'(1);
                end
                if (last_in_blk) begin
                    if (pass_end) begin
                        n_src = !r_src;
                        if (!sort_end) begin
                            // Start the next pass at twice the run width.
                            n_w   = w2;
                            n_i   = '0;
                            n_k   = '0;
                            n_mid = clamp_n(kss_pkg::t_wide'(w2), r_cnt);
                            n_j   = clamp_n(kss_pkg::t_wide'(w2), r_cnt);
                            n_hi  = clamp_n(kss_pkg::t_wide'(w2) << 1, r_cnt);
                        end
                    end else begin
                        // Advance to the next pair of runs.
                        n_i   = r_hi;
                        n_mid = clamp_n(kss_pkg::t_wide'(r_hi) + kss_pkg::t_wide'(r_w), r_cnt);
                        n_j   = clamp_n(kss_pkg::t_wide'(r_hi) + kss_pkg::t_wide'(r_w), r_cnt);
                        n_hi  = clamp_n(kss_pkg::t_wide'(r_hi) +
                                        (kss_pkg::t_wide'(r_w) << 1), r_cnt);
                    end
                end
            end
            kss_pkg::S_FRD: begin
                rd_addr0 = kss_pkg::t_addr'(r_rank - kss_pkg::t_rank'(1));
            end
            kss_pkg::S_FCAP: begin
                n_res_sel    = qi;
                n_res_status = kss_pkg::ST_OK;
            end
            kss_pkg::S_RES: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sel    = r_res_sel;
                    n_out_status = r_res_status;
                    n_cnt        = '0;
                    n_ovf        = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Reads of one memory only overlap writes to the other, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[a_waddr] <= a_wdata;
        end
        r_qa0 <= mem_a[rd_addr0];
        r_qa1 <= mem_a[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            mem_b[b_waddr] <= b_wdata;
        end
        r_qb0 <= mem_b[rd_addr0];
        r_qb1 <= mem_b[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kss_pkg::S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_rank      <= kss_pkg::t_rank'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w          <= n_w;
        r_i          <= n_i;
        r_j          <= n_j;
        r_k          <= n_k;
        r_mid        <= n_mid;
        r_hi         <= n_hi;
        r_src        <= n_src;
        r_res_sel    <= n_res_sel;
        r_res_status <= n_res_status;
        r_out_sel    <= n_out_sel;
        r_out_status <= n_out_status;
    end

    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kss_pkg::S_MWR) |->
            (r_k < r_cnt && r_i <= r_mid && r_mid <= r_j && r_j <= r_hi && r_hi <= r_cnt))
        else $error("merge pointers out of bounds");

    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kss_pkg::S_MWR) |-> (r_k == (r_i + r_j - r_mid)))
        else $error("merge output index does not match consumed elements");

    a_final_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kss_pkg::S_FRD) |->
            (r_rank != '0 && kss_pkg::t_cmp'(r_rank) <= kss_pkg::t_cmp'(r_cnt) && !r_ovf))
        else $error("final read with invalid rank");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kss_pkg::S_RES && out_free) |=>
            (r_cnt == '0 && !r_ovf && r_out_valid && r_state == kss_pkg::S_LOAD))
        else $error("data set not cleared after result");

endmodule

`default_nettype wire

// File: verif/tb_kth_smallest_select_unit.sv
// Testbench for kth_smallest_select_unit: directed and random sets against a rank predictor.
module tb_kth_smallest_select_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   IDLE_LIMIT  = 20000;
    localparam int   ITEM_TARGET = 1950;
    localparam int   DRAIN_PAD   = 8;
    localparam int   END_PAD     = 50;
    localparam int   SETS_PER_PHASE = 20;
    localparam kss_pkg::t_word WORD_MIN = 32'sh8000_0000;
    localparam kss_pkg::t_word WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        kss_pkg::t_word   selected;
        kss_pkg::t_status status;
    } t_pick;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  cfg_we;
    kss_pkg::t_rank cfg_wdata;

    kss_in_if  in_ch ();
    kss_out_if out_ch ();

    kth_smallest_select_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_data      (in_ch),
        .o_result    (out_ch)
    );

    // predictor state
    kss_pkg::t_word set_vals[$];
    bit             set_overflow = 1'b0;
    kss_pkg::t_rank rank_reg = kss_pkg::t_rank'(1);
    t_pick          picks_due[$];

    bit quiet = 1'b0;
    int n_fail = 0;
    int n_sent = 0;
    int n_sets = 0;
    int n_ok = 0;
    int n_rank_err = 0;
    int n_too_many = 0;
    int n_rank_writes = 0;
    int stalled_cycles = 0;

    always #5 i_clk = ~i_clk;

    function automatic t_pick predict_selection();
        kss_pkg::t_word ordered[$];
        kss_pkg::t_word tmp;
        t_pick p;
        int j;
        p.selected = '0;
        if (set_overflow) begin
            p.status = kss_pkg::ST_TOO_MANY;
        end else if (rank_reg == 0 || rank_reg > set_vals.size()) begin
            p.status = kss_pkg::ST_RANK;
        end else begin
            ordered = set_vals;
            for (int i = 1; i < ordered.size(); i++) begin
                tmp = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > tmp) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = tmp;
            end
            p.status   = kss_pkg::ST_OK;
            p.selected = ordered[rank_reg-1];
        end
        return p;
    endfunction

    // Input side: track every transfer and predict on the last item of a set.
    always @(posedge i_clk) begin
        t_pick p;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (set_vals.size() < kss_pkg::MAX_ITEMS)
                set_vals.push_back(in_ch.value);
            else
                set_overflow = 1'b1;
            if (in_ch.last) begin
                p = predict_selection();
                picks_due.push_back(p);
                n_sets++;
                case (p.status)
                    kss_pkg::ST_OK:       n_ok++;
                    kss_pkg::ST_RANK:     n_rank_err++;
                    kss_pkg::ST_TOO_MANY: n_too_many++;
                    default:              ;
                endcase
                set_vals.delete();
                set_overflow = 1'b0;
            end
        end
    end

    // Result side: compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (picks_due.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result selected=%0d status=%0d", $time,
                         out_ch.selected, out_ch.status);
            end else begin
                want = picks_due.pop_front();
                if (out_ch.selected !== want.selected) begin
                    n_fail++;
                    $display("%0t: selected mismatch, expected %0d, got %0d", $time,
                             want.selected, out_ch.selected);
                end
                if (out_ch.status !== want.status) begin
                    n_fail++;
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             want.status, out_ch.status);
                end
            end
        end
    end

    always @(posedge i_clk)
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 23);

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input kss_pkg::t_word v, input logic lst);
        while (!quiet && $urandom_range(0, 99) < 23) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (picks_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_rank(input kss_pkg::t_rank r);
        cfg_wdata <= r;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        rank_reg = r;
        n_rank_writes++;
    endtask

    function automatic kss_pkg::t_word draw_value(input int mode);
        case (mode)
            0: return kss_pkg::t_word'($urandom);
            1: return kss_pkg::t_word'(int'($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return kss_pkg::t_word'(0);
                    default: return kss_pkg::t_word'(-1);
                endcase
            end
        endcase
    endfunction

    task automatic send_set(input int size, input int mode);
        for (int i = 0; i < size; i++)
            send_item(draw_value(mode), i == size - 1);
    endtask

    task automatic test_default_rank();
        send_item(kss_pkg::t_word'(-5), 1'b1);
        send_item(WORD_MAX, 1'b0);
        send_item(WORD_MIN, 1'b0);
        send_item(kss_pkg::t_word'(0), 1'b0);
        send_item(kss_pkg::t_word'(-1), 1'b0);
        send_item(kss_pkg::t_word'(1), 1'b1);
    endtask

    task automatic test_rank_edges();
        wait_drain();
        write_rank(kss_pkg::t_rank'(0));
        send_item(kss_pkg::t_word'(7), 1'b1);
        wait_drain();
        write_rank(kss_pkg::t_rank'(3));
        send_item(kss_pkg::t_word'(4), 1'b0);
        send_item(kss_pkg::t_word'(9), 1'b1);
        // duplicates around the chosen rank
        send_item(kss_pkg::t_word'(5), 1'b0);
        send_item(kss_pkg::t_word'(5), 1'b0);
        send_item(kss_pkg::t_word'(-5), 1'b1);
        wait_drain();
        write_rank(kss_pkg::t_rank'(4));
        send_item(WORD_MIN, 1'b0);
        send_item(WORD_MAX, 1'b0);
        send_item(WORD_MAX, 1'b0);
        send_item(WORD_MIN, 1'b1);
    endtask

    task automatic test_capacity();
        wait_drain();
        write_rank(kss_pkg::t_rank'(256));
        send_set(kss_pkg::MAX_ITEMS, 0);
        send_set(kss_pkg::MAX_ITEMS + 1, 0);
        // over capacity wins over a bad rank
        wait_drain();
        write_rank(kss_pkg::t_rank'(0));
        send_set(kss_pkg::MAX_ITEMS + 2, 1);
    endtask

    task automatic test_random();
        int phase;
        int pick;
        int span;
        int size;
        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            wait_drain();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                write_rank(kss_pkg::t_rank'(0));
            else if (pick == 1)
                write_rank(kss_pkg::t_rank'(256));
            else if (pick == 2)
                write_rank(kss_pkg::t_rank'($urandom_range(13, 256)));
            else
                write_rank(kss_pkg::t_rank'($urandom_range(1, 12)));
            quiet = (phase == 2);
            for (int s = 0; s < SETS_PER_PHASE && n_sent < ITEM_TARGET; s++) begin
                span = (rank_reg + 2 > 40) ? 40 : rank_reg + 2;
                if ($urandom_range(0, 9) < 7)
                    size = $urandom_range(1, 12);
                else
                    size = $urandom_range(1, span);
                send_set(size, $urandom_range(0, 2));
                if ($urandom_range(0, 19) == 0)
                    wait_drain();
            end
            phase++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_rank();
        test_rank_edges();
        test_capacity();
        test_random();

        wait_drain();
        repeat (END_PAD) @(posedge i_clk);
        if (picks_due.size() != 0) begin
            n_fail++;
            $display("%0t: %0d results never arrived", $time, picks_due.size());
        end
        $display("Covered %0d data sets from %0d items: %0d ok, %0d rank out of range, %0d %s",
                 n_sets, n_sent, n_ok, n_rank_err, n_too_many, "over capacity.");
        $display("Rank rewritten %0d times (0, 1 and 256 among them) %s",
                 n_rank_writes, "under random stalls on both sides.");
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
